// File: rtl/core/lmrr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lmrr_pkg
// Shared types, codes and default sizes for the lock table engine.
// ----------------------------------------------------------------------------
package lmrr_pkg;

    localparam int DEF_NUM_LOCKS   = 256;
    localparam int DEF_QUEUE_DEPTH = 8;

    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 16;

    // request commands
    localparam logic CMD_ACQUIRE = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    // per-lock state codes, code 3 is unused
    localparam logic [1:0] LS_FREE   = 2'd0;
    localparam logic [1:0] LS_LOCKED = 2'd1;
    localparam logic [1:0] LS_REVOKE = 2'd2;

    // answer codes
    localparam logic [2:0] RC_OK        = 3'd0;
    localparam logic [2:0] RC_RETRY     = 3'd1;
    localparam logic [2:0] RC_RPCERR    = 3'd2;
    localparam logic [2:0] RC_IOERR     = 3'd3;
    localparam logic [2:0] RC_RETRYFAIL = 3'd4;
    localparam logic [2:0] RC_FULL      = 3'd5;

    typedef enum logic [1:0] {
        SQ_CLEAR,
        SQ_IDLE,
        SQ_EXEC,
        SQ_POP
    } seq_state_t;

    typedef struct packed {
        logic [2:0] status;
        logic       send_revoke;
        logic [3:0] revoke_target;
        logic       send_retry;
        logic [3:0] retry_target;
    } result_t;

    typedef struct packed {
        logic wr_entry;
        logic push;
        logic pop;
    } table_ctl_t;

    typedef struct packed {
        logic       command;
        logic [7:0] lock_id;
        logic [3:0] requester;
        logic       holder_reachable;
        logic       waiter_reachable;
        logic       retry_delivered;
    } request_t;

endpackage

`default_nettype wire

// File: rtl/core/lmrr_decide.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lmrr_decide
// Decision logic: from a request and the lock entry read from the table,
// works out the new entry, the queue operation and the answer.
// ----------------------------------------------------------------------------
module lmrr_decide #(
    parameter int NUM_LOCKS   = lmrr_pkg::DEF_NUM_LOCKS,
    parameter int QUEUE_DEPTH = lmrr_pkg::DEF_QUEUE_DEPTH,
    parameter int QH_W        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1,
    parameter int QC_W        = $clog2(QUEUE_DEPTH + 1)
) (
    input  var lmrr_pkg::request_t   req,
    input  wire                      cur_known,
    input  wire [1:0]                cur_state,
    input  wire [3:0]                cur_holder,
    input  wire [QH_W-1:0]           cur_head,
    input  wire [QC_W-1:0]           cur_count,
    input  wire [3:0]                waiter,
    output logic                     new_known,
    output logic [1:0]               new_state,
    output logic [3:0]               new_holder,
    output logic [QH_W-1:0]          new_head,
    output logic [QC_W-1:0]          new_count,
    output logic [QH_W-1:0]          tail,
    output lmrr_pkg::table_ctl_t     ctl,
    output lmrr_pkg::result_t        res
);
    import lmrr_pkg::*;

    localparam logic [16:0]     NL      = 17'(NUM_LOCKS);
    localparam logic [QC_W:0]   QD_SUM  = (QC_W + 1)'(QUEUE_DEPTH);
    localparam logic [QC_W-1:0] QD_CNT  = QC_W'(QUEUE_DEPTH);
    localparam logic [QH_W-1:0] HEAD_MX = QH_W'(QUEUE_DEPTH - 1);

    logic            in_range;
    logic            full;
    logic [QC_W:0]   pos_sum;
    logic [QC_W:0]   pos_wrap;
    logic [QH_W-1:0] head_inc;

    assign in_range = {9'd0, req.lock_id} < NL;
    assign full     = cur_count >= QD_CNT;

    // head + count stays below twice the depth
    assign pos_sum  = (QC_W + 1)'(cur_head) + (QC_W + 1)'(cur_count);
    assign pos_wrap = (pos_sum >= QD_SUM) ? pos_sum - QD_SUM : pos_sum;
    assign tail     = pos_wrap[QH_W-1:0];
    assign head_inc = (cur_head == HEAD_MX) ? '0 : cur_head + QH_W'(1);

    always_comb begin
        new_known  = cur_known;
        new_state  = cur_state;
        new_holder = cur_holder;
        new_head   = cur_head;
        new_count  = cur_count;
        ctl        = '0;
        res        = '0;
        res.status = RC_OK;

        if (!in_range) begin
            res.status = RC_IOERR;
        end else if (req.command == CMD_ACQUIRE) begin
            if (!cur_known) begin
                ctl.wr_entry = 1'b1;
                new_known    = 1'b1;
                new_state    = LS_LOCKED;
                new_holder   = req.requester;
                new_head     = '0;
                new_count    = '0;
            end else begin
                case (cur_state)
                    LS_FREE: begin
                        ctl.wr_entry = 1'b1;
                        new_state    = LS_LOCKED;
                        new_holder   = req.requester;
                        if (cur_count != '0 && req.holder_reachable) begin
                            res.send_revoke   = 1'b1;
                            res.revoke_target = req.requester;
                        end
                    end
                    LS_LOCKED: begin
                        if (!req.holder_reachable) begin
                            res.status = RC_RPCERR;
                        end else if (full) begin
                            res.status = RC_FULL;
                        end else begin
                            ctl.wr_entry      = 1'b1;
                            ctl.push          = 1'b1;
                            new_count         = cur_count + QC_W'(1);
                            new_state         = LS_REVOKE;
                            res.send_revoke   = 1'b1;
                            res.revoke_target = cur_holder;
                            res.status        = RC_RETRY;
                        end
                    end
                    LS_REVOKE: begin
                        if (full) begin
                            res.status = RC_FULL;
                        end else begin
                            ctl.wr_entry = 1'b1;
                            ctl.push     = 1'b1;
                            new_count    = cur_count + QC_W'(1);
                            res.status   = RC_RETRY;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end else begin
            if (!cur_known) begin
                res.status = RC_IOERR;
            end else if (cur_holder == req.requester && cur_state != LS_FREE) begin
                ctl.wr_entry = 1'b1;
                new_state    = LS_FREE;
                if (cur_count != '0) begin
                    ctl.pop   = 1'b1;
                    new_head  = head_inc;
                    new_count = cur_count - QC_W'(1);
                    if (req.waiter_reachable) begin
                        res.send_retry   = 1'b1;
                        res.retry_target = waiter;
                        res.status = req.retry_delivered ? RC_OK : RC_RETRYFAIL;
                    end else begin
                        res.status = RC_IOERR;
                    end
                end
            end
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/lock_manager_revoke_retry.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lock_manager_revoke_retry
// Lock table engine with revoke and retry messaging.
//
// Requests arrive on the s_axis channel, one per transaction, each naming a
// lock, a client and acquire or release. Every request gives exactly one
// answer transaction on m_axis, in request order.
// Lock entries sit in a table memory and waiter queues in a second memory,
// both with a registered read. A request is accepted, its lock entry read,
// then decided and written back once the output register is free; a release
// that pops a waiter reads the waiter memory in SQ_EXEC and writes back in
// SQ_POP, since that memory is read only once the entry gives the queue head.
// One request is in flight at a time. The answer waits in an output register;
// while the receiver stalls the block finishes the next request up to its
// write back and then holds it. After reset a clearing pass sweeps the table,
// during which s_axis_tready stays low.
// ----------------------------------------------------------------------------
module lock_manager_revoke_retry #(
    parameter int NUM_LOCKS   = lmrr_pkg::DEF_NUM_LOCKS,
    parameter int QUEUE_DEPTH = lmrr_pkg::DEF_QUEUE_DEPTH
) (
    input  wire                             aclk,
    input  wire                             aresetn,
    input  wire                             s_axis_tvalid,
    output logic                            s_axis_tready,
    // lock_id[7:0], requester[3:0], holder_reachable, waiter_reachable,
    // retry_delivered, zero fill
    input  wire [lmrr_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // command
    input  wire                             s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  wire                             m_axis_tready,
    // status[2:0], send_revoke, revoke_target[3:0], send_retry,
    // retry_target[3:0], zero fill
    output logic [lmrr_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import lmrr_pkg::*;

    localparam int LIDX_W = (NUM_LOCKS > 1) ? $clog2(NUM_LOCKS) : 1;
    localparam int QH_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QC_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int ENT_W  = 1 + 2 + 4 + QH_W + QC_W;
    localparam int WADR_W = LIDX_W + QH_W;
    localparam int WDEPTH = NUM_LOCKS * (2 ** QH_W);
    localparam logic [LIDX_W-1:0] CLR_LAST = LIDX_W'(NUM_LOCKS - 1);

    seq_state_t state_reg, state_next;

    logic [ENT_W-1:0] ent_mem [NUM_LOCKS];
    logic [3:0]       wait_mem [WDEPTH];

    request_t         req_reg;
    logic [ENT_W-1:0] ent_rd_reg;
    logic [3:0]       wait_rd_reg;
    logic [LIDX_W-1:0] clr_cnt_reg, clr_cnt_next;

    logic             m_valid_reg, m_valid_next;
    result_t          m_res_reg;

    request_t         s_req;
    logic [LIDX_W-1:0] s_idx;
    logic [LIDX_W-1:0] req_idx;
    logic             in_xfer;
    logic             out_free;
    logic             commit;
    logic             wait_rd_en;

    logic             cur_known;
    logic [1:0]       cur_state;
    logic [3:0]       cur_holder;
    logic [QH_W-1:0]  cur_head;
    logic [QC_W-1:0]  cur_count;

    logic             new_known;
    logic [1:0]       new_state;
    logic [3:0]       new_holder;
    logic [QH_W-1:0]  new_head;
    logic [QC_W-1:0]  new_count;
    logic [QH_W-1:0]  tail;
    table_ctl_t       ctl;
    result_t          res;

    assign s_req.command          = s_axis_tuser;
    assign s_req.lock_id          = s_axis_tdata[7:0];
    assign s_req.requester        = s_axis_tdata[11:8];
    assign s_req.holder_reachable = s_axis_tdata[12];
    assign s_req.waiter_reachable = s_axis_tdata[13];
    assign s_req.retry_delivered  = s_axis_tdata[14];

    assign s_idx   = LIDX_W'(s_req.lock_id);
    assign req_idx = LIDX_W'(req_reg.lock_id);

    assign {cur_known, cur_state, cur_holder, cur_head, cur_count} = ent_rd_reg;

    assign s_axis_tready = (state_reg == SQ_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !m_valid_reg || m_axis_tready;

    lmrr_decide #(
        .NUM_LOCKS   (NUM_LOCKS),
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .QH_W        (QH_W),
        .QC_W        (QC_W)
    ) u_decide (
        .req        (req_reg),
        .cur_known  (cur_known),
        .cur_state  (cur_state),
        .cur_holder (cur_holder),
        .cur_head   (cur_head),
        .cur_count  (cur_count),
        .waiter     (wait_rd_reg),
        .new_known  (new_known),
        .new_state  (new_state),
        .new_holder (new_holder),
        .new_head   (new_head),
        .new_count  (new_count),
        .tail       (tail),
        .ctl        (ctl),
        .res        (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= SQ_CLEAR;
            clr_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        m_valid_next = m_valid_reg && !m_axis_tready;
        commit       = 1'b0;
        wait_rd_en   = 1'b0;
        case (state_reg)
            SQ_CLEAR: begin
                clr_cnt_next = clr_cnt_reg + LIDX_W'(1);
                if (clr_cnt_reg == CLR_LAST) begin
                    state_next = SQ_IDLE;
                end
            end
            SQ_IDLE: begin
                if (in_xfer) begin
                    state_next = SQ_EXEC;
                end
            end
            SQ_EXEC: begin
                if (ctl.pop) begin
                    wait_rd_en = 1'b1;
                    state_next = SQ_POP;
                end else if (out_free) begin
                    commit       = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = SQ_IDLE;
                end
            end
            SQ_POP: begin
                if (out_free) begin
                    commit       = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = SQ_IDLE;
                end
            end
            default: begin
                state_next = SQ_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            req_reg <= s_req;
        end
        if (commit) begin
            m_res_reg <= res;
        end
    end

    // lock entry table
    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            ent_rd_reg <= ent_mem[s_idx];
        end
        if (state_reg == SQ_CLEAR) begin
            ent_mem[clr_cnt_reg] <= '0;
        end else if (commit && ctl.wr_entry) begin
            ent_mem[req_idx] <= {new_known, new_state, new_holder, new_head, new_count};
        end
    end

    // waiter rings, one row of slots per lock
    always_ff @(posedge aclk) begin
        if (wait_rd_en) begin
            wait_rd_reg <= wait_mem[WADR_W'({req_idx, cur_head})];
        end
        if (commit && ctl.push) begin
            wait_mem[WADR_W'({req_idx, tail})] <= req_reg.requester;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {3'd0, m_res_reg.retry_target, m_res_reg.send_retry,
                            m_res_reg.revoke_target, m_res_reg.send_revoke,
                            m_res_reg.status};

endmodule

`default_nettype wire

// File: dv/tb_lock_manager_revoke_retry.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lock_manager_revoke_retry
// Self-checking bench for the lock table engine. A directed run walks lock 0
// and lock 255 through creation, revoke, a full waiter queue, every release
// outcome and the grant of a freed lock. Random traffic then hammers a few hot
// locks, mostly releasing as the current holder, mixed with arbitrary requests.
// Each request is predicted on acceptance and each answer is checked in order.
// ----------------------------------------------------------------------------
module tb_lock_manager_revoke_retry;
    import lmrr_pkg::*;

    localparam int NLOCKS     = DEF_NUM_LOCKS;
    localparam int QDEPTH     = DEF_QUEUE_DEPTH;
    localparam int CYCLE_CAP  = 200000;
    localparam int TAIL_WAIT  = 16;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic                   s_tuser = 1'b0;
    logic                   m_tready = 1'b0;
    wire                    s_axis_tready;
    wire                    m_axis_tvalid;
    wire [OUT_TDATA_W-1:0]  m_axis_tdata;

    // lock table copies: index 0 tracks accepted requests, index 1 the generator
    bit          m_known  [2][NLOCKS];
    logic [1:0]  m_state  [2][NLOCKS];
    logic [3:0]  m_holder [2][NLOCKS];
    logic [3:0]  m_ring   [2][NLOCKS][QDEPTH];
    logic [2:0]  m_head   [2][NLOCKS];
    logic [3:0]  m_count  [2][NLOCKS];

    // request bits here: command lowest, then the tdata fields
    logic [IN_TDATA_W-1:0] pending_requests[$];
    result_t               expected_answers[$];

    int      send_idle_pct = 16;
    int      recv_stall_pct = 79;
    int      err_count = 0;
    int      answer_count = 0;
    int      cycles = 0;
    int      hot_locks[4];
    result_t got_answer;
    result_t want_answer;

    lock_manager_revoke_retry #(
        .NUM_LOCKS   (NLOCKS),
        .QUEUE_DEPTH (QDEPTH)
    ) uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_tdata),
        .s_axis_tuser  (s_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #6 aclk = ~aclk;

    function automatic request_t unpack_request(input logic [IN_TDATA_W-1:0] bits);
        request_t rq;
        rq.command          = bits[0];
        rq.lock_id          = bits[8:1];
        rq.requester        = bits[12:9];
        rq.holder_reachable = bits[13];
        rq.waiter_reachable = bits[14];
        rq.retry_delivered  = bits[15];
        return rq;
    endfunction

    function automatic logic [IN_TDATA_W-1:0] make_request(input logic cmd, input int lk,
            input int cid, input bit hr, input bit wr, input bit rd);
        return {rd, wr, hr, 4'(cid), 8'(lk), cmd};
    endfunction

    function automatic void push_waiter(input int inst, input int lk, input logic [3:0] cid);
        logic [2:0] tail;
        tail = m_head[inst][lk] + 3'(m_count[inst][lk]);
        m_ring[inst][lk][tail] = cid;
        m_count[inst][lk] = m_count[inst][lk] + 4'd1;
    endfunction

    // answer to one request, updating the chosen copy of the lock table
    function automatic result_t apply_request(input int inst, input request_t rq);
        result_t    rs;
        int         lk;
        logic [3:0] popped;
        rs = '0;
        rs.status = RC_OK;
        lk = rq.lock_id;
        if (lk >= NLOCKS) begin
            rs.status = RC_IOERR;
        end else if (rq.command == CMD_ACQUIRE) begin
            if (!m_known[inst][lk]) begin
                m_known[inst][lk]  = 1'b1;
                m_state[inst][lk]  = LS_LOCKED;
                m_holder[inst][lk] = rq.requester;
                m_head[inst][lk]   = '0;
                m_count[inst][lk]  = '0;
            end else if (m_state[inst][lk] == LS_FREE) begin
                m_state[inst][lk]  = LS_LOCKED;
                m_holder[inst][lk] = rq.requester;
                // waiters left behind: a reachable new holder gets revoked at once
                if (m_count[inst][lk] != 0 && rq.holder_reachable) begin
                    rs.send_revoke   = 1'b1;
                    rs.revoke_target = rq.requester;
                end
            end else if (m_state[inst][lk] == LS_LOCKED) begin
                if (!rq.holder_reachable) begin
                    rs.status = RC_RPCERR;
                end else if (m_count[inst][lk] >= QDEPTH) begin
                    rs.status = RC_FULL;
                end else begin
                    push_waiter(inst, lk, rq.requester);
                    m_state[inst][lk] = LS_REVOKE;
                    rs.send_revoke    = 1'b1;
                    rs.revoke_target  = m_holder[inst][lk];
                    rs.status         = RC_RETRY;
                end
            end else if (m_state[inst][lk] == LS_REVOKE) begin
                if (m_count[inst][lk] >= QDEPTH) begin
                    rs.status = RC_FULL;
                end else begin
                    push_waiter(inst, lk, rq.requester);
                    rs.status = RC_RETRY;
                end
            end
        end else begin
            if (!m_known[inst][lk]) begin
                rs.status = RC_IOERR;
            end else if (m_holder[inst][lk] == rq.requester && m_state[inst][lk] != LS_FREE) begin
                m_state[inst][lk] = LS_FREE;
                if (m_count[inst][lk] != 0) begin
                    popped = m_ring[inst][lk][m_head[inst][lk]];
                    m_head[inst][lk]  = m_head[inst][lk] + 3'd1;
                    m_count[inst][lk] = m_count[inst][lk] - 4'd1;
                    if (rq.waiter_reachable) begin
                        rs.send_retry   = 1'b1;
                        rs.retry_target = popped;
                        rs.status = rq.retry_delivered ? RC_OK : RC_RETRYFAIL;
                    end else begin
                        rs.status = RC_IOERR;
                    end
                end
            end
        end
        return rs;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("answer %0d: %s mismatch, got %0d expected %0d", answer_count, what, got, want);
        err_count++;
    endtask

    task automatic queue_request(input logic [IN_TDATA_W-1:0] bits);
        void'(apply_request(1, unpack_request(bits)));
        pending_requests.push_back(bits);
    endtask

    task automatic queue_random_request();
        logic [IN_TDATA_W-1:0] bits;
        int   lk;
        int   cid;
        logic cmd;
        if ($urandom_range(99) < 10) begin
            bits = 16'($urandom);
        end else begin
            lk  = ($urandom_range(99) < 85) ? hot_locks[$urandom_range(3)] : $urandom_range(255);
            cmd = ($urandom_range(99) < 55) ? CMD_ACQUIRE : CMD_RELEASE;
            cid = $urandom_range(15);
            if (cmd == CMD_RELEASE && m_known[1][lk] && $urandom_range(99) < 75)
                cid = m_holder[1][lk];
            bits = make_request(cmd, lk, cid, $urandom_range(99) < 85,
                                $urandom_range(99) < 85, $urandom_range(99) < 85);
        end
        queue_request(bits);
    endtask

    task automatic wait_drained();
        while (pending_requests.size() != 0 || s_tvalid || expected_answers.size() != 0)
            @(negedge aclk);
    endtask

    // request driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_axis_tready) begin
            if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                s_tvalid          <= 1'b1;
                {s_tdata, s_tuser} <= {1'b0, pending_requests.pop_front()};
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // monitor: predict on request acceptance, check on answer acceptance
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_axis_tready)
                expected_answers.push_back(apply_request(0,
                    unpack_request({s_tdata[IN_TDATA_W-2:0], s_tuser})));
            if (m_axis_tvalid && m_tready) begin
                got_answer.status        = m_axis_tdata[2:0];
                got_answer.send_revoke   = m_axis_tdata[3];
                got_answer.revoke_target = m_axis_tdata[7:4];
                got_answer.send_retry    = m_axis_tdata[8];
                got_answer.retry_target  = m_axis_tdata[12:9];
                if (expected_answers.size() == 0) begin
                    report_mismatch("unexpected transaction, status", got_answer.status, 0);
                end else begin
                    want_answer = expected_answers.pop_front();
                    if (got_answer.status != want_answer.status)
                        report_mismatch("status", got_answer.status, want_answer.status);
                    if (got_answer.send_revoke != want_answer.send_revoke)
                        report_mismatch("send_revoke", got_answer.send_revoke,
                                        want_answer.send_revoke);
                    if (got_answer.revoke_target != want_answer.revoke_target)
                        report_mismatch("revoke_target", got_answer.revoke_target,
                                        want_answer.revoke_target);
                    if (got_answer.send_retry != want_answer.send_retry)
                        report_mismatch("send_retry", got_answer.send_retry,
                                        want_answer.send_retry);
                    if (got_answer.retry_target != want_answer.retry_target)
                        report_mismatch("retry_target", got_answer.retry_target,
                                        want_answer.retry_target);
                end
                answer_count++;
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_CAP) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < 4; i++)
            hot_locks[i] = $urandom_range(255);
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // lock 0 through its whole life, plus lock 255
        queue_request(make_request(CMD_ACQUIRE, 0, 0, 1, 1, 1));   // created and granted
        queue_request(make_request(CMD_ACQUIRE, 0, 5, 0, 1, 1));   // holder unreachable
        queue_request(make_request(CMD_ACQUIRE, 0, 5, 1, 0, 0));   // revoke the holder
        for (int c = 6; c <= 12; c++)                               // revoke out, fill queue
            queue_request(make_request(CMD_ACQUIRE, 0, c, c % 2, 1, 0));
        queue_request(make_request(CMD_ACQUIRE, 0, 13, 1, 1, 1));  // queue full
        queue_request(make_request(CMD_RELEASE, 0, 3, 1, 1, 1));   // not the holder
        queue_request(make_request(CMD_RELEASE, 255, 15, 1, 1, 1)); // unknown lock
        queue_request(make_request(CMD_RELEASE, 0, 0, 0, 1, 1));   // pop, retry delivered
        queue_request(make_request(CMD_ACQUIRE, 0, 5, 1, 0, 0));   // grant with waiters
        queue_request(make_request(CMD_RELEASE, 0, 5, 1, 0, 1));   // waiter unreachable
        queue_request(make_request(CMD_ACQUIRE, 0, 15, 0, 1, 1));  // grant, no revoke
        queue_request(make_request(CMD_RELEASE, 0, 15, 0, 1, 0));  // retry not delivered
        queue_request(make_request(CMD_RELEASE, 0, 15, 1, 1, 1));  // lock already free
        queue_request(make_request(CMD_ACQUIRE, 255, 15, 1, 1, 1));
        queue_request(make_request(CMD_RELEASE, 255, 15, 1, 1, 1)); // empty queue
        queue_request(make_request(CMD_ACQUIRE, 255, 0, 1, 0, 0));
        queue_request(make_request(CMD_RELEASE, 255, 0, 0, 0, 0));
        wait_drained();

        repeat (130) queue_random_request();
        wait_drained();

        send_idle_pct  = 79;
        recv_stall_pct = 16;
        repeat (130) queue_random_request();
        wait_drained();

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (140) queue_random_request();
        wait_drained();

        repeat (TAIL_WAIT) @(negedge aclk);
        if (err_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// File: files.f
rtl/core/lmrr_pkg.sv
rtl/core/lmrr_decide.sv
rtl/core/lock_manager_revoke_retry.sv
dv/tb_lock_manager_revoke_retry.sv
